FILE: sv/command_line_tokenizer_macros.svh
// Assertion macros for the command line tokenizer; empty bodies under synthesis.
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define CLT_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tokenizer assertion failed");
// Check that cons holds in the clock after ante.
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");
`else
`define CLT_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/cltok_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the command line tokenizer.
package cltok_pkg;

    localparam logic [7:0] QUOTE_CHAR   = 8'h22;
    localparam logic [7:0] ESCAPE_CHAR  = 8'h5C;
    localparam logic [7:0] MARKER_RESET = 8'd45;
    localparam logic [7:0] CHAR_N       = 8'h6E;
    localparam logic [7:0] CHAR_R       = 8'h72;
    localparam logic [7:0] CHAR_T       = 8'h74;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_VT      = 8'h0B;
    localparam logic [7:0] CHAR_FF      = 8'h0C;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam int APB_AW = 3;
    localparam logic REG_MARKER = 1'b0;

    localparam logic ROLE_COMMAND  = 1'b0;
    localparam logic ROLE_ARGUMENT = 1'b1;

    typedef enum logic [3:0] {
        M_BETWEEN = 4'b0001,
        M_PLAIN   = 4'b0010,
        M_QUOTED  = 4'b0100,
        M_SKIP    = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       role;
        logic       token_end;
        logic       line_end;
    } t_out;

    typedef struct packed {
        logic [1:0] cnt;
        t_out       res0;
        t_out       res1;
    } t_push;

    typedef struct packed {
        t_mode      mode;
        logic       esc;
        logic [7:0] held;
        logic [1:0] tlen;
        logic       is_cmd;
        logic       cmd_open;
    } t_tok_state;

    typedef struct packed {
        t_tok_state st;
        t_push      ps;
    } t_work;

endpackage

FILE: sv/cltok_core.sv
`timescale 1ns / 1ps
// Tokenizer state and per-byte scan logic producing up to two results.
module cltok_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  cltok_pkg::t_in    i_item,
    input  logic [7:0]        i_marker,
    output cltok_pkg::t_push  o_push
);
    import cltok_pkg::*;

    t_tok_state r_st;
    t_work      n_work;

    function automatic logic f_is_space(input logic [7:0] c);
        return c inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR, CHAR_VT, CHAR_FF};
    endfunction

    function automatic logic [7:0] f_unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CHAR_N:  r = CHAR_LF;
            CHAR_R:  r = CHAR_CR;
            CHAR_T:  r = CHAR_TAB;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic t_push f_emit(input t_push p, input logic [7:0] c,
                                     input logic vld, input logic role,
                                     input logic tend);
        t_push q;
        t_out  o;
        q = p;
        o.out_char   = c;
        o.char_valid = vld;
        o.role       = role;
        o.token_end  = tend;
        o.line_end   = 1'b0;
        if (p.cnt == 2'd0) begin
            q.res0 = o;
            q.cnt  = 2'd1;
        end else if (p.cnt == 2'd1) begin
            q.res1 = o;
            q.cnt  = 2'd2;
        end
        return q;
    endfunction

    function automatic t_work f_add_char(input t_work w, input logic [7:0] c,
                                         input logic [7:0] marker);
        t_work v;
        v = w;
        if (w.st.tlen == 2'd0) begin
            v.st.held = c;
            v.st.tlen = 2'd1;
        end else if (w.st.tlen == 2'd1) begin
            if (w.st.held == marker && !f_is_space(c)) begin
                v.st.is_cmd   = 1'b1;
                v.st.cmd_open = 1'b1;
            end else if (w.st.cmd_open) begin
                v.ps = f_emit(w.ps, w.st.held, 1'b1, ROLE_ARGUMENT, 1'b0);
            end
            v.st.held = c;
            v.st.tlen = 2'd2;
        end else begin
            if (w.st.cmd_open) begin
                v.ps = f_emit(w.ps, w.st.held, 1'b1,
                              w.st.is_cmd ? ROLE_COMMAND : ROLE_ARGUMENT, 1'b0);
            end
            v.st.held = c;
        end
        return v;
    endfunction

    function automatic t_work f_end_token(input t_work w);
        t_work v;
        v = w;
        if (w.st.tlen != 2'd0 && w.st.cmd_open) begin
            v.ps = f_emit(w.ps, w.st.held, 1'b1,
                          w.st.is_cmd ? ROLE_COMMAND : ROLE_ARGUMENT, 1'b1);
        end
        v.st.tlen   = 2'd0;
        v.st.held   = 8'h00;
        v.st.is_cmd = 1'b0;
        v.st.esc    = 1'b0;
        return v;
    endfunction

    always_comb begin
        n_work.st = r_st;
        n_work.ps = '0;
        case (r_st.mode)
            M_BETWEEN: begin
                if (!f_is_space(i_item.in_byte)) begin
                    if (i_item.in_byte == QUOTE_CHAR) begin
                        n_work.st.mode = M_QUOTED;
                    end else if (i_item.in_byte == ESCAPE_CHAR) begin
                        n_work.st.mode = M_PLAIN;
                        n_work.st.esc  = 1'b1;
                    end else begin
                        n_work.st.mode = M_PLAIN;
                        n_work = f_add_char(n_work, i_item.in_byte, i_marker);
                    end
                end
            end
            M_PLAIN: begin
                if (r_st.esc) begin
                    n_work.st.esc = 1'b0;
                    n_work = f_add_char(n_work, f_unescape(i_item.in_byte), i_marker);
                end else if (i_item.in_byte == ESCAPE_CHAR) begin
                    n_work.st.esc = 1'b1;
                end else if (f_is_space(i_item.in_byte)) begin
                    n_work = f_end_token(n_work);
                    n_work.st.mode = M_BETWEEN;
                end else begin
                    n_work = f_add_char(n_work, i_item.in_byte, i_marker);
                end
            end
            M_QUOTED: begin
                if (r_st.esc) begin
                    n_work.st.esc = 1'b0;
                    n_work = f_add_char(n_work, f_unescape(i_item.in_byte), i_marker);
                end else if (i_item.in_byte == ESCAPE_CHAR) begin
                    n_work.st.esc = 1'b1;
                end else if (i_item.in_byte == QUOTE_CHAR) begin
                    n_work = f_end_token(n_work);
                    n_work.st.mode = M_SKIP;
                end else begin
                    n_work = f_add_char(n_work, i_item.in_byte, i_marker);
                end
            end
            default: begin
                n_work.st.mode = M_BETWEEN;
            end
        endcase

        if (i_item.line_last) begin
            if (n_work.st.mode == M_PLAIN || n_work.st.mode == M_QUOTED) begin
                if (n_work.st.esc) begin
                    n_work.st.esc = 1'b0;
                    n_work = f_add_char(n_work, ESCAPE_CHAR, i_marker);
                end
                n_work = f_end_token(n_work);
            end
            if (n_work.ps.cnt == 2'd0) begin
                n_work.ps = f_emit(n_work.ps, 8'h00, 1'b0, ROLE_COMMAND, 1'b0);
            end
            if (n_work.ps.cnt == 2'd1) begin
                n_work.ps.res0.line_end = 1'b1;
            end else begin
                n_work.ps.res1.line_end = 1'b1;
            end
            n_work.st.mode     = M_BETWEEN;
            n_work.st.esc      = 1'b0;
            n_work.st.cmd_open = 1'b0;
            n_work.st.tlen     = 2'd0;
            n_work.st.held     = 8'h00;
            n_work.st.is_cmd   = 1'b0;
        end
    end

    always_comb begin
        o_push = n_work.ps;
        if (!i_fire) begin
            o_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode     <= M_BETWEEN;
            r_st.esc      <= 1'b0;
            r_st.held     <= 8'h00;
            r_st.tlen     <= 2'd0;
            r_st.is_cmd   <= 1'b0;
            r_st.cmd_open <= 1'b0;
        end else if (i_fire) begin
            r_st <= n_work.st;
        end
    end

endmodule

FILE: sv/cltok_fifo.sv
`timescale 1ns / 1ps
// Four-entry result queue: push up to two results, pop one per beat.
`include "command_line_tokenizer_macros.svh"
module cltok_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cltok_pkg::t_push  i_push,
    output logic              o_room2,
    output logic              o_valid,
    input  logic              i_stall,
    output cltok_pkg::t_out   o_data
);
    import cltok_pkg::*;

    t_out       r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign o_room2 = (r_count <= 3'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    assign n_count = r_count + {1'b0, i_push.cnt} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push.cnt;
            r_rd_ptr <= r_rd_ptr + {1'b0, pop};
            r_count  <= n_count;
        end
    end

    `CLT_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= 3'd4)
    `CLT_ASSERT_ALWAYS(a_push_room, i_clk, i_rst_n, (i_push.cnt == 2'd0) || o_room2)
    `CLT_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, 1'b1, r_count == $past(n_count))
    `CLT_ASSERT_NEXT(a_ptr_gap, i_clk, i_rst_n, 1'b1, r_wr_ptr == r_rd_ptr + r_count[1:0])

endmodule

FILE: sv/command_line_tokenizer.sv
`timescale 1ns / 1ps
// Command line tokenizer top level: input register, scan core, result queue, APB.
// Path: a taken byte is held in the input register, scanned into the result queue once
//   the queue has room for two results, and leaves from the head of the queue.
// Throughput: one byte per cycle while the result queue has room for two results; a byte
//   that yields two results needs two output beats, and the four-entry queue absorbs one.
// Reset (i_rst_n low, synchronous): scan state between tokens, queue and input
//   register empty, command marker back to '-'.
module command_line_tokenizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input beats
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cltok_pkg::t_in                 i_in_data,
    // result beats
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cltok_pkg::t_out                o_out_data,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cltok_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import cltok_pkg::*;

    logic       r_in_valid;
    t_in        r_in;
    logic [7:0] r_marker;
    logic       accept;
    logic       fire;
    logic       room2;
    t_push      push;

    // Scan the held byte once the queue can take both of its possible results.
    assign fire       = r_in_valid && room2;
    // Stall only while a held byte cannot move on; an empty slot always takes a beat.
    assign o_in_stall = r_in_valid && !room2;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !fire);
        end
    end

    // Payload register: load on every accepted beat, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // Marker register: written at the access phase of an APB write.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= MARKER_RESET;
        end else if (psel && penable && pwrite && paddr[APB_AW-1] == REG_MARKER) begin
            r_marker <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[APB_AW-1] == REG_MARKER) begin
            prdata = {24'd0, r_marker};
        end
    end

    // Per-byte mode logic; its results go straight into the queue.
    cltok_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_marker (r_marker),
        .o_push   (push)
    );

    // Results wait here so a stalled output does not block input beats until the queue fills.
    cltok_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room2  (room2),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_data   (o_out_data)
    );

endmodule
